>>> sv/arcsin_series_evaluator_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the arcsin series evaluator
// Concurrent checks that are compiled for simulation and become empty for
// synthesis.
// ----------------------------------------------------------------------------
`ifndef ARCSIN_SERIES_EVALUATOR_ASSERT_SVH
`define ARCSIN_SERIES_EVALUATOR_ASSERT_SVH
`ifndef SYNTHESIS
// The property must hold at every clock edge outside reset.
`define ASE_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// The expression must never be true outside reset.
`define ASE_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define ASE_ASSERT(lbl, clk, rst_n, prop, msg)
`define ASE_NEVER(lbl, clk, rst_n, expr, msg)
`endif
`endif

>>> sv/ase_pkg.sv
// ----------------------------------------------------------------------------
// ase_pkg
// Shared widths, codes and controller/datapath interface types of the
// arcsin series evaluator.
// ----------------------------------------------------------------------------
package ase_pkg;

    localparam int Q_FRAC    = 30;
    localparam int X_W       = 32;
    localparam int TOL_W     = 32;
    localparam int SUM_W     = 32;
    localparam int TERMS_W   = 11;
    localparam int PROD_W    = 2 * Q_FRAC;
    localparam int DIV_CNT_W = $clog2(Q_FRAC);
    localparam int OUT_DATA_W = 48;

    localparam logic [TOL_W-1:0]   TOL_RESET = 32'd1073742;
    localparam logic [TERMS_W-1:0] TERMS_SAT = 11'd2047;
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(Q_FRAC - 1);

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_X_RANGE    = 2'd1,
        ST_TOL_RANGE  = 2'd2,
        ST_TERM_LIMIT = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        MUL_SQ = 2'd0,
        MUL_X2 = 2'd1,
        MUL_N  = 2'd2
    } t_mul_sel;

    typedef struct packed {
        logic     load_x;
        logic     mul_en;
        t_mul_sel mul_sel;
        logic     init;
        logic     acc;
        logic     m_from_prod;
        logic     div_load;
        logic     div_step;
        logic     div_last;
        logic     den_plus2;
        logic     n_inc;
        logic     out_load;
        t_status  out_status;
    } t_cmd;

    typedef struct packed {
        logic x_bad;
        logic tol_bad;
        logic stop;
        logic at_limit;
        logic out_busy;
    } t_sts;

endpackage

>>> sv/ase_ctrl.sv
// ----------------------------------------------------------------------------
// ase_ctrl
// Sequencer of the series evaluation: range checks, term loop and the two
// long divisions of every term.
// ----------------------------------------------------------------------------
`include "arcsin_series_evaluator_assert.svh"

module ase_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  ase_pkg::t_sts i_sts,
    output logic          o_ready,
    output ase_pkg::t_cmd o_cmd
);
    import ase_pkg::*;

    typedef enum logic [11:0] {
        S_IDLE   = 12'b0000_0000_0001,
        S_CHECK  = 12'b0000_0000_0010,
        S_SQUARE = 12'b0000_0000_0100,
        S_TEST   = 12'b0000_0000_1000,
        S_SCALE  = 12'b0000_0001_0000,
        S_MUL_N1 = 12'b0000_0010_0000,
        S_LOAD1  = 12'b0000_0100_0000,
        S_DIV1   = 12'b0000_1000_0000,
        S_MUL_N2 = 12'b0001_0000_0000,
        S_LOAD2  = 12'b0010_0000_0000,
        S_DIV2   = 12'b0100_0000_0000,
        S_DONE   = 12'b1000_0000_0000
    } t_state;

    t_state               r_state, n_state;
    t_status              r_status, n_status;
    logic [DIV_CNT_W-1:0] r_div_cnt, n_div_cnt;

    always_comb begin
        n_state   = r_state;
        n_status  = r_status;
        n_div_cnt = r_div_cnt;
        o_cmd     = '0;
        o_ready   = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_start) begin
                    o_cmd.load_x = 1'b1;
                    n_state      = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_sts.x_bad) begin
                    n_status = ST_X_RANGE;
                    n_state  = S_DONE;
                end else if (i_sts.tol_bad) begin
                    n_status = ST_TOL_RANGE;
                    n_state  = S_DONE;
                end else begin
                    o_cmd.mul_en  = 1'b1;
                    o_cmd.mul_sel = MUL_SQ;
                    n_state       = S_SQUARE;
                end
            end
            S_SQUARE: begin
                o_cmd.init = 1'b1;
                n_state    = S_TEST;
            end
            S_TEST: begin
                if (i_sts.stop) begin
                    n_status = ST_OK;
                    n_state  = S_DONE;
                end else if (i_sts.at_limit) begin
                    n_status = ST_TERM_LIMIT;
                    n_state  = S_DONE;
                end else begin
                    o_cmd.acc     = 1'b1;
                    o_cmd.mul_en  = 1'b1;
                    o_cmd.mul_sel = MUL_X2;
                    n_state       = S_SCALE;
                end
            end
            S_SCALE: begin
                o_cmd.m_from_prod = 1'b1;
                n_state           = S_MUL_N1;
            end
            S_MUL_N1: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_N;
                n_state       = S_LOAD1;
            end
            S_LOAD1: begin
                o_cmd.div_load = 1'b1;
                n_div_cnt      = '0;
                n_state        = S_DIV1;
            end
            S_DIV1: begin
                o_cmd.div_step = 1'b1;
                if (r_div_cnt == DIV_LAST) begin
                    o_cmd.div_last = 1'b1;
                    n_div_cnt      = '0;
                    n_state        = S_MUL_N2;
                end else begin
                    n_div_cnt = r_div_cnt + 1'b1;
                end
            end
            S_MUL_N2: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_N;
                n_state       = S_LOAD2;
            end
            S_LOAD2: begin
                o_cmd.div_load = 1'b1;
                n_div_cnt      = '0;
                n_state        = S_DIV2;
            end
            S_DIV2: begin
                o_cmd.div_step  = 1'b1;
                o_cmd.den_plus2 = 1'b1;
                if (r_div_cnt == DIV_LAST) begin
                    o_cmd.div_last = 1'b1;
                    o_cmd.n_inc    = 1'b1;
                    n_div_cnt      = '0;
                    n_state        = S_TEST;
                end else begin
                    n_div_cnt = r_div_cnt + 1'b1;
                end
            end
            S_DONE: begin
                if (!i_sts.out_busy) begin
                    o_cmd.out_load   = 1'b1;
                    o_cmd.out_status = r_status;
                    n_state          = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_status  <= ST_OK;
            r_div_cnt <= '0;
        end else begin
            r_state   <= n_state;
            r_status  <= n_status;
            r_div_cnt <= n_div_cnt;
        end
    end

    // A started item always goes through the range check first.
    `ASE_ASSERT(a_start_to_check, i_clk, i_rst_n, i_start |=> r_state == S_CHECK, "start did not enter check")
    // The step counter only runs while a division is in progress.
    `ASE_ASSERT(a_div_cnt_idle, i_clk, i_rst_n, (r_div_cnt != '0) |-> (r_state == S_DIV1 || r_state == S_DIV2), "division counter runs outside a division")
    // No result can be written in the cycle right after an item starts.
    `ASE_ASSERT(a_no_early_result, i_clk, i_rst_n, i_start |=> !o_cmd.out_load, "result written before the check")

endmodule

>>> sv/ase_datapath.sv
// ----------------------------------------------------------------------------
// ase_datapath
// Term registers, shared 30x30 multiplier, restoring divider, accumulator,
// tolerance register and result register.
// ----------------------------------------------------------------------------
`include "arcsin_series_evaluator_assert.svh"

module ase_datapath #(
    parameter int MAX_TERMS = 1024
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  ase_pkg::t_cmd                   i_cmd,
    output ase_pkg::t_sts                   o_sts,
    input  logic [ase_pkg::X_W-1:0]         i_x_value,
    input  logic                            i_cfg_wr_en,
    input  logic [ase_pkg::TOL_W-1:0]       i_cfg_wr_data,
    input  logic                            i_out_ready,
    output logic                            o_out_valid,
    output logic [ase_pkg::SUM_W-1:0]       o_sum_value,
    output logic [1:0]                      o_status,
    output logic [ase_pkg::TERMS_W-1:0]     o_terms_used
);
    import ase_pkg::*;

    localparam int NW    = $clog2(2 * MAX_TERMS + 2);
    localparam int CW    = $clog2(MAX_TERMS + 1);
    localparam int CNT_W = (CW > TERMS_W) ? CW : TERMS_W;

    logic [TOL_W-1:0]   r_tol;
    logic               r_neg;
    logic               r_x_bad;
    logic [Q_FRAC-1:0]  r_xmag;
    logic [Q_FRAC-1:0]  r_x2;
    logic [Q_FRAC-1:0]  r_m;
    logic [NW-1:0]      r_n;
    logic [SUM_W-2:0]   r_sum;
    logic [CNT_W-1:0]   r_count;
    logic [PROD_W-1:0]  r_prod;
    logic [NW-1:0]      r_rem;
    logic [Q_FRAC-1:0]  r_lo;
    logic               r_out_valid;
    logic [SUM_W-1:0]   r_out_sum;
    t_status            r_out_status;
    logic [TERMS_W-1:0] r_out_terms;

    logic [X_W-1:0]     w_x_abs;
    logic [Q_FRAC-1:0]  w_op_a, w_op_b;
    logic [NW-1:0]      w_den;
    logic [NW:0]        w_shift, w_diff;
    logic               w_ge;
    logic [NW-1:0]      n_rem;
    logic [Q_FRAC-1:0]  n_lo;
    logic [SUM_W-1:0]   w_sum;
    logic [SUM_W-1:0]   w_sum_wide;
    logic [TERMS_W-1:0] w_terms;
    logic               w_err;

    assign w_x_abs = i_x_value[X_W-1] ? (~i_x_value + 32'd1) : i_x_value;

    always_comb begin
        case (i_cmd.mul_sel)
            MUL_SQ: begin
                w_op_a = r_xmag;
                w_op_b = r_xmag;
            end
            MUL_X2: begin
                w_op_a = r_m;
                w_op_b = r_x2;
            end
            MUL_N: begin
                w_op_a = r_m;
                w_op_b = Q_FRAC'(r_n);
            end
            default: begin
                w_op_a = r_m;
                w_op_b = r_x2;
            end
        endcase
    end

    // One quotient bit per step; the remainder always stays below the divisor.
    assign w_den   = r_n + (i_cmd.den_plus2 ? NW'(2) : NW'(1));
    assign w_shift = {r_rem, r_lo[Q_FRAC-1]};
    assign w_diff  = w_shift - {1'b0, w_den};
    assign w_ge    = (w_shift >= {1'b0, w_den});
    assign n_rem   = w_ge ? w_diff[NW-1:0] : w_shift[NW-1:0];
    assign n_lo    = {r_lo[Q_FRAC-2:0], w_ge};

    // The sum only grows, so clamping each addition equals clamping at the end.
    assign w_sum = SUM_W'(r_sum) + SUM_W'(r_m);

    assign w_sum_wide = r_neg ? (~{1'b0, r_sum} + 32'd1) : {1'b0, r_sum};
    assign w_terms    = (r_count > CNT_W'(TERMS_SAT)) ? TERMS_SAT : r_count[TERMS_W-1:0];
    assign w_err      = (i_cmd.out_status == ST_X_RANGE) || (i_cmd.out_status == ST_TOL_RANGE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol       <= TOL_RESET;
            r_out_valid <= 1'b0;
            r_count     <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_tol <= i_cfg_wr_data;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.init) begin
                r_count <= '0;
            end else if (i_cmd.acc) begin
                r_count <= r_count + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_x) begin
            r_neg   <= i_x_value[X_W-1];
            r_xmag  <= w_x_abs[Q_FRAC-1:0];
            r_x_bad <= !((i_x_value[X_W-1:Q_FRAC] == 2'b00) ||
                         ((i_x_value[X_W-1:Q_FRAC] == 2'b11) &&
                          (i_x_value[Q_FRAC-1:0] != '0)));
        end
        if (i_cmd.mul_en) begin
            r_prod <= w_op_a * w_op_b;
        end
        if (i_cmd.init) begin
            r_x2    <= r_prod[PROD_W-1:Q_FRAC];
            r_m     <= r_xmag;
            r_n     <= NW'(1);
            r_sum   <= '0;
        end
        if (i_cmd.acc) begin
            r_sum   <= w_sum[SUM_W-1] ? {(SUM_W-1){1'b1}} : w_sum[SUM_W-2:0];
        end
        if (i_cmd.m_from_prod) begin
            r_m <= r_prod[PROD_W-1:Q_FRAC];
        end
        if (i_cmd.div_load) begin
            r_rem <= r_prod[Q_FRAC+NW-1:Q_FRAC];
            r_lo  <= r_prod[Q_FRAC-1:0];
        end
        if (i_cmd.div_step) begin
            r_rem <= n_rem;
            r_lo  <= n_lo;
        end
        if (i_cmd.div_last) begin
            r_m <= n_lo;
        end
        if (i_cmd.n_inc) begin
            r_n <= r_n + NW'(2);
        end
        if (i_cmd.out_load) begin
            r_out_status <= i_cmd.out_status;
            r_out_sum    <= w_err ? '0 : w_sum_wide;
            r_out_terms  <= w_err ? '0 : w_terms;
        end
    end

    assign o_sts.x_bad    = r_x_bad;
    assign o_sts.tol_bad  = (r_tol == '0) || r_tol[TOL_W-1];
    assign o_sts.stop     = (TOL_W'({r_m, 1'b0}) <= r_tol);
    assign o_sts.at_limit = (r_count == CNT_W'(MAX_TERMS));
    assign o_sts.out_busy = r_out_valid && !i_out_ready;

    assign o_out_valid  = r_out_valid;
    assign o_sum_value  = r_out_sum;
    assign o_status     = r_out_status;
    assign o_terms_used = r_out_terms;

    // The term count never passes the limit.
    `ASE_NEVER(a_count_limit, i_clk, i_rst_n, r_count > CNT_W'(MAX_TERMS), "term count above limit")
    // A range error reports an empty result.
    `ASE_ASSERT(a_err_empty, i_clk, i_rst_n, (r_out_valid && (r_out_status == ST_X_RANGE || r_out_status == ST_TOL_RANGE)) |-> (r_out_sum == '0 && r_out_terms == '0), "error result not empty")
    // The partial remainder must stay below the divisor during a division.
    `ASE_ASSERT(a_rem_below_den, i_clk, i_rst_n, i_cmd.div_step |-> (r_rem < w_den), "division remainder out of range")

endmodule

>>> sv/arcsin_series_evaluator.sv
// ----------------------------------------------------------------------------
// arcsin_series_evaluator
// Computes arcsin(x) in signed Q1.30 by summing its Taylor series until a
// term falls to the programmable tolerance.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Signals                          Contents
//  -------   ---------  -------------------------------  ---------------------------
//  input     in         i_s_tvalid/o_s_tready/i_s_tdata   x_value
//  result    out        o_m_tvalid/i_m_tready/o_m_tdata   sum_value, terms_used
//                       o_m_tuser                         status
//  config    in         i_cfg_wr_en/i_cfg_wr_data         tolerance (write only)
//
// The number of terms summed for an item is at most MAX_TERMS; a range error
// ends the item without summing any term.
// Every term costs two 30-step restoring divisions on the single divider and
// three passes through the shared 30x30 multiplier, so the divider sets the rate.
// Reset is synchronous and active low; it restores the tolerance to its
// default and empties the result register.
// One item is worked at a time; the next item is taken as soon as the result
// is parked in the output register, even while the consumer stalls.
//
module arcsin_series_evaluator #(
    parameter int MAX_TERMS = 1024
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Input item.
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    input  logic [ase_pkg::X_W-1:0]            i_s_tdata,   // [31:0] x_value
    // Result item.
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    output logic [ase_pkg::OUT_DATA_W-1:0]     o_m_tdata,   // [31:0] sum_value,
                                                            // [42:32] terms_used,
                                                            // [47:43] zero
    output logic [1:0]                         o_m_tuser,   // [1:0] status
    // Tolerance register, unsigned Q1.31.
    input  logic                               i_cfg_wr_en,
    input  logic [ase_pkg::TOL_W-1:0]          i_cfg_wr_data
);
    import ase_pkg::*;

    t_cmd               w_cmd;
    t_sts               w_sts;
    logic               w_ready;
    logic               w_start;
    logic [SUM_W-1:0]   w_sum_value;
    logic [TERMS_W-1:0] w_terms_used;

    // An item is taken whenever the sequencer is idle; the result register
    // decouples it from the consumer.
    assign o_s_tready = w_ready;
    assign w_start    = i_s_tvalid && w_ready;

    ase_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_sts   (w_sts),
        .o_ready (w_ready),
        .o_cmd   (w_cmd)
    );

    ase_datapath #(
        .MAX_TERMS (MAX_TERMS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_x_value     (i_s_tdata),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_out_ready   (i_m_tready),
        .o_out_valid   (o_m_tvalid),
        .o_sum_value   (w_sum_value),
        .o_status      (o_m_tuser),
        .o_terms_used  (w_terms_used)
    );

    // Pack the result fields from the lowest bit up and pad to whole bytes.
    assign o_m_tdata = {{(OUT_DATA_W - SUM_W - TERMS_W){1'b0}}, w_terms_used, w_sum_value};

endmodule
